// File: hw/rtl/image_rle_decoder_core_macros.svh
// Assertion macros for the image RLE decoder core.
// Used by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef IMAGE_RLE_DECODER_CORE_MACROS_SVH
`define IMAGE_RLE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IRLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/irle_pkg.sv
// Shared types and constants for the image RLE decoder core.
// No dependencies; used by irle_ctrl, irle_dp and image_rle_decoder_core.
package irle_pkg;

  localparam logic [7:0] RunMark     = 8'hBF;
  localparam logic [2:0] HeaderBytes = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       last;
    logic       image_done;
    logic       clipped;
  } out_item_t;

  typedef enum logic [2:0] {
    OpNone,
    OpHeader,
    OpDrop,
    OpRunLoad,
    OpRunMark,
    OpLiteral,
    OpRunEmit
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic hdr_done;     // all four header bytes seen
    logic pix_zero;     // no pixels left in the image
    logic run_pending;  // run count seen, next item is the value
    logic cnt_one;      // final copy of the active run
    logic out_free;     // output register can take a result this cycle
  } status_t;

endpackage

// File: hw/rtl/image_rle_decoder_core.sv
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+-------------------------------
// input    | in_valid_i / in_ready_o         | in_data_i  (irle_pkg::in_item_t)
// output   | out_valid_o / out_ready_i       | out_data_o (irle_pkg::out_item_t)
//
// Header, literal, run-count and ignored bytes are each handled as they are taken; a
// run value byte is loaded, then its copies (1..64) go out one per cycle while the output
// does not stall, with the input held off until its last copy is registered.
// The output register lets an item be taken in the cycle its predecessor's
// result is read; output stalls hold the run sequencer and the input.
// Async active-low reset clears all state but val_q and out_q; no clearing pass.
// Top level of the image RLE decoder; depends on irle_pkg, irle_ctrl, irle_dp.
module image_rle_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  irle_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output irle_pkg::out_item_t out_data_o
);

  irle_pkg::cmd_t    cmd;
  irle_pkg::status_t st;

  irle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_data_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  irle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .byte_i      (in_data_i.data_byte),
    .out_ready_i (out_ready_i),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_data_o)
  );

endmodule

// File: hw/rtl/irle_ctrl.sv
// Controller FSM for the image RLE decoder: classifies each item, sequences runs.
// Depends on irle_pkg.
module irle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  irle_pkg::in_item_t in_item_i,
  input  irle_pkg::status_t  st_i,
  output logic               in_ready_o,
  output irle_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op    = irle_pkg::OpNone;
    cmd_o.start = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = st_i.out_free;
        if (in_valid_i && st_i.out_free) begin
          cmd_o.start = in_item_i.start_image;
          if (in_item_i.start_image || !st_i.hdr_done) begin
            cmd_o.op = irle_pkg::OpHeader;
          end else if (st_i.pix_zero) begin
            cmd_o.op = irle_pkg::OpDrop;
          end else if (st_i.run_pending) begin
            cmd_o.op = irle_pkg::OpRunLoad;
            state_d  = StRun;
          end else if (in_item_i.data_byte > irle_pkg::RunMark) begin
            cmd_o.op = irle_pkg::OpRunMark;
          end else begin
            cmd_o.op = irle_pkg::OpLiteral;
          end
        end
      end
      StRun: begin
        if (st_i.out_free) begin
          cmd_o.op = irle_pkg::OpRunEmit;
          if (st_i.cnt_one) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/irle_dp.sv
// Datapath for the image RLE decoder: header fields, pixel and run counters,
// width*height multiplier and the output register. Depends on irle_pkg and the macros header.
`include "image_rle_decoder_core_macros.svh"

module irle_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irle_pkg::cmd_t      cmd_i,
  input  logic [7:0]          byte_i,
  input  logic                out_ready_i,
  output irle_pkg::status_t   st_o,
  output logic                out_valid_o,
  output irle_pkg::out_item_t out_item_o
);

  logic [2:0]  hp_q, hp_d;
  logic [15:0] width_q, width_d;
  logic [7:0]  hlo_q, hlo_d;
  logic [31:0] pix_q, pix_d;
  logic        run_pend_q, run_pend_d;
  logic [6:0]  run_len_q, run_len_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [7:0]  val_q, val_d;
  logic        clip_q, clip_d;
  logic        out_valid_q, out_valid_d;
  irle_pkg::out_item_t out_q, out_d;

  logic [2:0]  hdr_pos;
  logic [15:0] width_base;
  logic [31:0] prod;
  logic [7:0]  mark_diff;
  logic        run_clip;
  logic        pix_one;

  assign hdr_pos    = cmd_i.start ? 3'd0 : hp_q;
  assign width_base = cmd_i.start ? 16'd0 : width_q;
  assign prod       = {16'd0, width_q} * {16'd0, byte_i, hlo_q};
  assign mark_diff  = byte_i - irle_pkg::RunMark;
  assign pix_one    = (pix_q == 32'd1);
  // run longer than what is left of the image
  assign run_clip   = (pix_q[31:7] == '0) && (pix_q[6:0] < run_len_q);

  assign st_o.hdr_done    = (hp_q == irle_pkg::HeaderBytes);
  assign st_o.pix_zero    = (pix_q == '0);
  assign st_o.run_pending = run_pend_q;
  assign st_o.cnt_one     = (cnt_q == 7'd1);
  assign st_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    hp_d        = hp_q;
    width_d     = width_q;
    hlo_d       = hlo_q;
    pix_d       = pix_q;
    run_pend_d  = run_pend_q;
    run_len_d   = run_len_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (cmd_i.op)
      irle_pkg::OpHeader: begin
        run_pend_d = 1'b0;
        if (cmd_i.start) begin
          pix_d = '0;
        end
        case (hdr_pos[1:0])
          2'd0:    width_d = {width_base[15:8], byte_i};
          2'd1:    width_d = {byte_i, width_q[7:0]};
          2'd2:    hlo_d   = byte_i;
          default: pix_d   = prod;
        endcase
        hp_d        = hdr_pos + 3'd1;
        out_valid_d = 1'b1;
        out_d       = '{out_byte: byte_i, is_header: 1'b1, last: 1'b1,
                        image_done: 1'b0, clipped: 1'b0};
      end
      irle_pkg::OpDrop: begin
        run_pend_d = 1'b0;
      end
      irle_pkg::OpRunLoad: begin
        run_pend_d = 1'b0;
        clip_d     = run_clip;
        cnt_d      = run_clip ? pix_q[6:0] : run_len_q;
        val_d      = byte_i;
      end
      irle_pkg::OpRunMark: begin
        run_pend_d = 1'b1;
        run_len_d  = mark_diff[6:0];
      end
      irle_pkg::OpLiteral: begin
        pix_d       = pix_q - 32'd1;
        out_valid_d = 1'b1;
        out_d       = '{out_byte: byte_i, is_header: 1'b0, last: 1'b1,
                        image_done: pix_one, clipped: 1'b0};
      end
      irle_pkg::OpRunEmit: begin
        pix_d       = pix_q - 32'd1;
        cnt_d       = cnt_q - 7'd1;
        out_valid_d = 1'b1;
        out_d       = '{out_byte: val_q, is_header: 1'b0, last: st_o.cnt_one,
                        image_done: pix_one, clipped: clip_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= '0;
      width_q     <= '0;
      hlo_q       <= '0;
      pix_q       <= '0;
      run_pend_q  <= 1'b0;
      run_len_q   <= '0;
      cnt_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hp_q        <= hp_d;
      width_q     <= width_d;
      hlo_q       <= hlo_d;
      pix_q       <= pix_d;
      run_pend_q  <= run_pend_d;
      run_len_q   <= run_len_d;
      cnt_q       <= cnt_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `IRLE_ASSERT_IMPL(a_emit_has_work, cmd_i.op == irle_pkg::OpRunEmit, cnt_q != '0 && pix_q != '0, "run copy emitted with no count or no pixels left")
  `IRLE_ASSERT_IMPL(a_literal_has_pix, cmd_i.op == irle_pkg::OpLiteral, pix_q != '0, "literal taken with no pixels left")
  `IRLE_ASSERT_IMPL(a_done_is_last, out_valid_q && out_q.image_done, out_q.last, "image end not on the last result of its item")
  `IRLE_ASSERT_IMPL(a_hdr_pos_range, hp_q[2], hp_q[1:0] == 2'd0, "header position beyond four")
  `IRLE_ASSERT_NEXT(a_hdr_result, cmd_i.op == irle_pkg::OpHeader, out_valid_q && out_q.is_header, "header item left no header result")

endmodule
